// ----- src/kgr_pkg.sv -----
// ============================================================================
// kgr_pkg - shared types and constants of the key grid ripple effect
// Ripple codes, operation codes, level constants and the per-cell update rule.
// ============================================================================
package kgr_pkg;

    // default grid bounds and frame size
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;
    localparam int FRAME_CAP    = 64;

    typedef logic signed [7:0] code_t;
    typedef logic signed [6:0] key_t;
    typedef logic signed [6:0] pix_t;

    // operation codes
    localparam logic [1:0] OP_SET_KEY   = 2'd0;
    localparam logic [1:0] OP_SET_PIXEL = 2'd1;
    localparam logic [1:0] OP_TRIGGER   = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    // register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // ripple codes
    localparam code_t RC_NONE    = 8'sd0;
    localparam code_t RC_ALL     = 8'sd1;
    localparam code_t RC_UP_R    = 8'sd2;
    localparam code_t RC_LEFT_U  = 8'sd3;
    localparam code_t RC_RIGHT_D = 8'sd4;
    localparam code_t RC_DOWN_L  = 8'sd5;
    localparam code_t RC_UP      = 8'sd6;
    localparam code_t RC_LEFT    = 8'sd7;
    localparam code_t RC_RIGHT   = 8'sd8;
    localparam code_t RC_DOWN    = 8'sd9;
    localparam code_t RC_SPENT   = 8'sd10;

    // blue levels
    localparam logic [4:0] LEVEL_DIM    = 5'd5;
    localparam logic [4:0] LEVEL_BRIGHT = 5'd30;

    // neighbour presence of one cell
    typedef struct packed {
        logic in_grid;
        logic has_up;
        logic has_down;
        logic has_left;
        logic has_right;
    } kgr_bound_t;

    // control of the cell row
    typedef struct packed {
        logic shift;
        logic update;
    } kgr_ctrl_t;

    // New code of one cell on a tick. Writers land in index order, so the
    // cell below wins over the right one, then the cell itself, then left, up.
    function automatic code_t kgr_next_code(input code_t c, input code_t up,
                                            input code_t dn, input code_t lf,
                                            input code_t rt, input kgr_bound_t b);
        code_t r;
        r = c;
        if (b.in_grid)
        begin
            if (b.has_down && (dn == RC_ALL || dn == RC_UP_R))
                r = RC_UP_R;
            else if (b.has_down && (dn == RC_LEFT_U || dn == RC_UP))
                r = RC_UP;
            else if (b.has_right && (rt == RC_ALL || rt == RC_LEFT_U))
                r = RC_LEFT_U;
            else if (b.has_right && (rt == RC_DOWN_L || rt == RC_LEFT))
                r = RC_LEFT;
            else if (c >= RC_ALL && c <= RC_DOWN)
                r = RC_SPENT;
            else if (c > RC_DOWN)
                r = RC_NONE;
            else if (b.has_left && (lf == RC_ALL || lf == RC_RIGHT_D))
                r = RC_RIGHT_D;
            else if (b.has_left && (lf == RC_UP_R || lf == RC_RIGHT))
                r = RC_RIGHT;
            else if (b.has_up && (up == RC_ALL || up == RC_DOWN_L))
                r = RC_DOWN_L;
            else if (b.has_up && (up == RC_RIGHT_D || up == RC_DOWN))
                r = RC_DOWN;
        end
        return r;
    endfunction

endpackage

// ----- src/key_grid_ripple_led_effect.sv -----
// ============================================================================
// key_grid_ripple_led_effect - ripple light effect over a key grid
// Ring of cells holding ripple codes and keys, key-to-pixel RAM, frame RAM.
// ============================================================================
// Set-key and trigger words take one full turn of the ring of min(MAX_ROWS
// * MAX_COLS, 64) cells. Set-pixel words are written as they are accepted. A
// tick goes through one update step, one ring turn to build the frame, one
// drain step and then a read step and a load step per pixel for row_count *
// column_count pixels (at most the ring size), waiting while the result side
// stalls. The ring walk through a single head position and the one-read frame
// RAM shape this sequence. A new word is taken once the previous one is
// finished, while its last result may still wait in the output register.
module key_grid_ripple_led_effect
    import kgr_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  operation,
    input  logic [5:0]  position,
    input  logic signed [6:0] key,
    input  logic signed [7:0] value,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [5:0]  pixel,
    output logic [4:0]  blue_level,
    output logic        last
);

    localparam int GRID  = MAX_ROWS * MAX_COLS;
    localparam int NCELL = (GRID < FRAME_CAP) ? GRID : FRAME_CAP;
    localparam int CW    = (NCELL > 1) ? $clog2(NCELL) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROT   = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [5:0]  oc_reg, oc_next;
    logic        found_reg, found_next;
    logic [1:0]  op_reg;
    logic [5:0]  pos_reg;
    key_t        key_reg;
    code_t       value_reg;
    logic [3:0]  rows_reg, cols_reg;
    logic [6:0]  len_reg;
    logic [7:0]  prod;

    logic        item_acc;
    logic        cfg_we;
    logic [3:0]  cfg_val;
    logic        cnt_wrap;
    logic [6:0]  cnt7;

    code_t       cell_code [NCELL];
    key_t        cell_key  [NCELL];
    code_t       head_code;
    key_t        head_key;
    kgr_ctrl_t   ctrl;

    logic [FRAME_CAP-1:0] kp_valid_reg;
    logic        kp_we;
    pix_t        kp_rdata;
    logic        kpv_reg;
    logic        s1_valid_reg;
    logic [4:0]  s1_level_reg;
    pix_t        pix_sel;
    logic        fr_we;
    logic [4:0]  fr_rdata;
    logic [FRAME_CAP-1:0] fr_flag_reg;
    logic        fr_flag_q;
    logic        out_free;

    logic        result_valid_reg;
    logic [5:0]  pixel_reg;
    logic [4:0]  blue_reg;
    logic        last_reg;

    // configuration writes and reads
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_val = pwdata[3:0];
    assign prdata  = {28'd0, (paddr[2] == REG_COLS) ? cols_reg : rows_reg};
    assign prod    = rows_reg * cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 4'd1;
            cols_reg <= 4'd1;
            len_reg  <= 7'd1;
        end
        else
        begin
            if (cfg_we && paddr[2] == REG_ROWS)
                rows_reg <= (cfg_val == 4'd0) ? 4'd1 :
                            (32'(cfg_val) > MAX_ROWS) ? 4'(MAX_ROWS) : cfg_val;
            if (cfg_we && paddr[2] == REG_COLS)
                cols_reg <= (cfg_val == 4'd0) ? 4'd1 :
                            (32'(cfg_val) > MAX_COLS) ? 4'(MAX_COLS) : cfg_val;
            len_reg <= (32'(prod) > NCELL) ? 7'(NCELL) : 7'(prod);
        end
    end

    // ring of cells with neighbour selection
    assign ctrl.shift  = (state_reg == S_ROT) || (state_reg == S_SCAN);
    assign ctrl.update = (state_reg == S_UPD);

    genvar gj, gk;
    generate
        for (gj = 0; gj < NCELL; gj++)
        begin : g_cell
            localparam logic [7:0] JV = 8'(gj);
            localparam int LI = (gj > 0) ? gj - 1 : gj;
            localparam int RI = (gj + 1 < NCELL) ? gj + 1 : gj;
            code_t      up_opt [MAX_COLS];
            code_t      dn_opt [MAX_COLS];
            logic [3:0] col_opt [MAX_COLS];
            code_t      up_c, dn_c;
            logic [3:0] col;
            code_t      ch_code;
            key_t       ch_key;
            kgr_bound_t bound;

            for (gk = 1; gk <= MAX_COLS; gk++)
            begin : g_col
                localparam int UI = (gj >= gk) ? gj - gk : gj;
                localparam int DI = (gj + gk < NCELL) ? gj + gk : gj;
                localparam logic [3:0] CV = 4'(gj % gk);
                assign up_opt[gk-1]  = cell_code[UI];
                assign dn_opt[gk-1]  = cell_code[DI];
                assign col_opt[gk-1] = CV;
            end

            // select by the column count in use
            always_comb
            begin
                up_c = RC_NONE;
                dn_c = RC_NONE;
                col  = 4'd0;
                for (int k = 0; k < MAX_COLS; k++)
                begin
                    if (32'(cols_reg) == k + 1)
                    begin
                        up_c = up_opt[k];
                        dn_c = dn_opt[k];
                        col  = col_opt[k];
                    end
                end
            end

            assign bound.in_grid   = JV < {1'b0, len_reg};
            assign bound.has_up    = JV >= {4'd0, cols_reg};
            assign bound.has_down  = (JV + {4'd0, cols_reg}) < {1'b0, len_reg};
            assign bound.has_left  = col != 4'd0;
            assign bound.has_right = (col != cols_reg - 4'd1) &&
                                     ((JV + 8'd1) < {1'b0, len_reg});

            if (gj == NCELL - 1)
            begin : g_tail
                assign ch_code = head_code;
                assign ch_key  = head_key;
            end
            else
            begin : g_body
                assign ch_code = cell_code[gj+1];
                assign ch_key  = cell_key[gj+1];
            end

            kgr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .chain_code (ch_code),
                .chain_key  (ch_key),
                .up_code    (up_c),
                .dn_code    (dn_c),
                .lf_code    (cell_code[LI]),
                .rt_code    (cell_code[RI]),
                .bound      (bound),
                .code       (cell_code[gj]),
                .key        (cell_key[gj])
            );
        end
    endgenerate

    // modify the head cell as it wraps round
    assign cnt7     = 7'(cnt_reg);
    assign cnt_wrap = (cnt_reg == CW'(NCELL - 1));

    always_comb
    begin
        head_code  = cell_code[0];
        head_key   = cell_key[0];
        found_next = found_reg;
        if (state_reg == S_ROT && op_reg == OP_SET_KEY && cnt7 == {1'b0, pos_reg})
            head_key = value_reg[6:0];
        if (state_reg == S_ROT && op_reg == OP_TRIGGER && !found_reg &&
            cnt7 < len_reg && cell_key[0] == key_reg)
        begin
            head_code  = value_reg;
            found_next = 1'b1;
        end
        if (state_reg == S_IDLE)
            found_next = 1'b0;
    end

    // key-to-pixel map, reads -1 until written
    assign kp_we = item_acc && operation == OP_SET_PIXEL && 32'(position) < NCELL;

    kgr_ram #(.WIDTH(7), .DEPTH(FRAME_CAP)) u_kp_ram (
        .clk   (clk),
        .we    (kp_we),
        .waddr (position),
        .wdata (value[6:0]),
        .raddr (cell_key[0][5:0]),
        .rdata (kp_rdata)
    );

    // frame build: stage one looks up the pixel, stage two writes the level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_valid_reg <= '0;
            s1_valid_reg <= 1'b0;
            fr_flag_reg  <= '0;
        end
        else
        begin
            if (kp_we)
                kp_valid_reg[position] <= 1'b1;
            s1_valid_reg <= (state_reg == S_SCAN) && cnt7 < len_reg &&
                            cell_code[0] != RC_NONE && !cell_key[0][6] &&
                            32'(cell_key[0]) < NCELL;
            if (state_reg == S_UPD)
                fr_flag_reg <= '0;
            else if (fr_we)
                fr_flag_reg[pix_sel[5:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        kpv_reg      <= kp_valid_reg[cell_key[0][5:0]];
        s1_level_reg <= (cell_code[0] >= RC_UP && cell_code[0] <= RC_SPENT) ?
                        LEVEL_DIM : LEVEL_BRIGHT;
    end

    assign pix_sel = kpv_reg ? kp_rdata : '1;
    assign fr_we   = s1_valid_reg && !pix_sel[6] && {1'b0, pix_sel[5:0]} < len_reg;

    kgr_ram #(.WIDTH(5), .DEPTH(FRAME_CAP)) u_fr_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (pix_sel[5:0]),
        .wdata (s1_level_reg),
        .raddr (oc_reg),
        .rdata (fr_rdata)
    );

    always_ff @(posedge clk)
    begin
        fr_flag_q <= fr_flag_reg[oc_reg];
    end

    // sequencer
    assign item_stall = (state_reg != S_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        oc_next    = oc_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                oc_next  = 6'd0;
                if (item_acc)
                begin
                    if (operation == OP_TICK)
                        state_next = S_UPD;
                    else if (operation != OP_SET_PIXEL)
                        state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cnt_next = cnt_wrap ? '0 : cnt_reg + CW'(1);
                if (cnt_wrap)
                    state_next = S_IDLE;
            end
            S_UPD:
                state_next = S_SCAN;
            S_SCAN:
            begin
                cnt_next = cnt_wrap ? '0 : cnt_reg + CW'(1);
                if (cnt_wrap)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_RD;
            S_RD:
                if (out_free)
                    state_next = S_LOAD;
            S_LOAD:
            begin
                if ({1'b0, oc_reg} == len_reg - 7'd1)
                    state_next = S_IDLE;
                else
                begin
                    oc_next    = oc_reg + 6'd1;
                    state_next = S_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            oc_reg    <= 6'd0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            oc_reg    <= oc_next;
            found_reg <= found_next;
        end
    end

    // hold the accepted word
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            op_reg    <= operation;
            pos_reg   <= position;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (state_reg == S_LOAD)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            pixel_reg <= oc_reg;
            blue_reg  <= fr_flag_q ? fr_rdata : 5'd0;
            last_reg  <= ({1'b0, oc_reg} == len_reg - 7'd1);
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel        = pixel_reg;
    assign blue_level   = blue_reg;
    assign last         = last_reg;

    // checks
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_LOAD)
        else $error("result shown outside load");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> cnt_reg == '0)
        else $error("ring not aligned at idle");

    a_frame_write: assert property (@(posedge clk) disable iff (!rst_n)
        fr_we |-> $past(state_reg) == S_SCAN)
        else $error("frame write outside scan");

    a_found_trig: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> op_reg == OP_TRIGGER)
        else $error("match flag outside trigger");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |-> !result_valid_reg || !$past(result_stall))
        else $error("result overwritten");

endmodule

// ----- src/kgr_ram.sv -----
// ============================================================================
// kgr_ram - generic single write, single read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module kgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- src/kgr_cell.sv -----
// ============================================================================
// kgr_cell - one cell of the key grid ring
// Holds a ripple code and a key number; shifts along the ring or updates.
// ============================================================================
module kgr_cell
    import kgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  kgr_ctrl_t  ctrl,
    input  code_t      chain_code,
    input  key_t       chain_key,
    input  code_t      up_code,
    input  code_t      dn_code,
    input  code_t      lf_code,
    input  code_t      rt_code,
    input  kgr_bound_t bound,
    output code_t      code,
    output key_t       key
);

    code_t code_reg, code_next;
    key_t  key_reg, key_next;

    // pick update, shift or hold
    always_comb
    begin
        code_next = code_reg;
        key_next  = key_reg;
        if (ctrl.update)
            code_next = kgr_next_code(code_reg, up_code, dn_code, lf_code, rt_code, bound);
        else if (ctrl.shift)
        begin
            code_next = chain_code;
            key_next  = chain_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= RC_NONE;
            key_reg  <= '1;
        end
        else
        begin
            code_reg <= code_next;
            key_reg  <= key_next;
        end
    end

    assign code = code_reg;
    assign key  = key_reg;

endmodule

// ----- sim/key_grid_ripple_led_effect_test.sv -----
// ============================================================================
// key_grid_ripple_led_effect_test - regression of the key grid ripple effect
// Drives map loads, triggers and ticks with random gaps, predicts every frame
// pixel in a local model of the grid and compares each result word with it.
// ============================================================================
module key_grid_ripple_led_effect_test
    import kgr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       op;
        logic [5:0]       pos;
        logic signed [6:0] k;
        logic signed [7:0] val;
    } grid_word_t;

    typedef struct packed {
        logic [5:0] pix;
        logic [4:0] lvl;
        logic       lst;
    } pixel_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  operation;
    logic [5:0]  position;
    logic signed [6:0] key;
    logic signed [7:0] value;
    logic        result_valid;
    logic        result_stall;
    logic [5:0]  pixel;
    logic [4:0]  blue_level;
    logic        last;

    key_grid_ripple_led_effect uut (.*);

    // local copy of the block state
    int          grid_rows;
    int          grid_cols;
    logic signed [7:0] codes [64];
    logic signed [6:0] cell_keys [64];
    logic signed [6:0] key_pixels [64];

    grid_word_t  pending_words [$];
    pixel_word_t expected_pixels [$];
    int          mismatches;
    int          cycles;
    bit          hold_long;
    int          hold_cycles;
    bit          gap_enable;
    int          stall_left;
    int          stall_gap;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // overall cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 5000000)
        begin
            $display("key_grid_ripple_led_effect regression: fail");
            $finish;
        end
    end

    function automatic int clamp_count(input logic [31:0] v);
        int n;
        n = int'(v[3:0]);
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        return n;
    endfunction

    // write one code during a tick, dropping writes off the grid
    function automatic void put_code(input int idx, input int len, input int c);
        if (idx >= 0 && idx < len)
            codes[idx] = 8'(c);
    endfunction

    // apply one word to the local state and queue the pixels a tick emits
    function automatic void predict_word(input grid_word_t w);
        logic signed [7:0] snap [64];
        logic [4:0] levels [64];
        int len, cols, c, kk, p;
        bit up, dn, lf, rt;
        pixel_word_t pw;
        len = grid_rows * grid_cols;
        cols = grid_cols;
        case (w.op)
            OP_SET_KEY:   cell_keys[w.pos] = w.val[6:0];
            OP_SET_PIXEL: key_pixels[w.pos] = w.val[6:0];
            OP_TRIGGER:
            begin
                for (int i = 0; i < len; i++)
                    if (cell_keys[i] == w.k)
                    begin
                        codes[i] = w.val;
                        break;
                    end
            end
            default:
            begin
                snap = codes;
                for (int i = 0; i < len; i++)
                begin
                    c = snap[i];
                    up = i >= cols;
                    dn = i < len - cols;
                    lf = (i % cols) > 0;
                    rt = (i % cols) < cols - 1;
                    case (c)
                        1:
                        begin
                            if (up) put_code(i - cols, len, 2);
                            if (dn) put_code(i + cols, len, 5);
                            if (lf) put_code(i - 1, len, 3);
                            if (rt) put_code(i + 1, len, 4);
                        end
                        2:
                        begin
                            if (up) put_code(i - cols, len, 2);
                            if (rt) put_code(i + 1, len, 8);
                        end
                        3:
                        begin
                            if (lf) put_code(i - 1, len, 3);
                            if (up) put_code(i - cols, len, 6);
                        end
                        4:
                        begin
                            if (rt) put_code(i + 1, len, 4);
                            if (dn) put_code(i + cols, len, 9);
                        end
                        5:
                        begin
                            if (dn) put_code(i + cols, len, 5);
                            if (lf) put_code(i - 1, len, 7);
                        end
                        6: if (up) put_code(i - cols, len, 6);
                        7: if (lf) put_code(i - 1, len, 7);
                        8: if (rt) put_code(i + 1, len, 8);
                        9: if (dn) put_code(i + cols, len, 9);
                        default: ;
                    endcase
                    if (c >= 1 && c <= 9)
                        codes[i] = RC_SPENT;
                    else if (c > 9)
                        codes[i] = RC_NONE;
                end
                for (int i = 0; i < 64; i++)
                    levels[i] = '0;
                for (int i = 0; i < len; i++)
                begin
                    c = codes[i];
                    kk = cell_keys[i];
                    if (c == 0 || kk < 0) continue;
                    p = key_pixels[kk];
                    if (p < 0 || p >= len) continue;
                    levels[p] = (c >= 6 && c <= 10) ? LEVEL_DIM : LEVEL_BRIGHT;
                end
                for (int i = 0; i < len; i++)
                begin
                    pw.pix = 6'(i);
                    pw.lvl = levels[i];
                    pw.lst = (i == len - 1);
                    expected_pixels.push_back(pw);
                end
            end
        endcase
    endfunction

    // draw a gap length: mostly none or short, sometimes long
    function automatic int draw_gap();
        int r;
        if (!gap_enable) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver: offer pending words, hold while stalled
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!(item_valid && item_stall))
        begin
            if (item_valid)
                predict_word({operation, position, key, value});
            if (send_gap > 0 || pending_words.size() == 0)
            begin
                item_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end
            else
            begin
                grid_word_t w;
                w = pending_words.pop_front();
                item_valid <= 1'b1;
                operation <= w.op;
                position <= w.pos;
                key <= w.k;
                value <= w.val;
                send_gap <= draw_gap();
            end
        end
    end

    // receiver stall: random stretches, or a long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_long)
        begin
            result_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_gap = draw_gap();
            result_stall <= (stall_gap > 0);
            stall_left <= (stall_gap > 0) ? stall_gap - 1 : 0;
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel word: pixel %0d level %0d last %0b",
                             pixel, blue_level, last);
            end
            else
            begin
                pixel_word_t e;
                e = expected_pixels.pop_front();
                if (e.pix !== pixel || e.lvl !== blue_level || e.lst !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 e.pix, e.lvl, e.lst, pixel, blue_level, last);
                end
            end
        end
    end

    task automatic add_word(input logic [1:0] op, input int pos, input int k,
                            input int val);
        grid_word_t w;
        w.op = op;
        w.pos = 6'(pos);
        w.k = 7'(k);
        w.val = 8'(val);
        pending_words.push_back(w);
    endtask

    // wait until sent, results drained, and ring work finished
    task automatic drain_all();
        while (pending_words.size() != 0 || item_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ROWS) grid_rows = clamp_count(data);
        else grid_cols = clamp_count(data);
    endtask

    task automatic random_burst(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                add_word(OP_SET_KEY, $urandom_range(0, 63),
                         0, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 20));
            else if (r < 38)
                add_word(OP_SET_PIXEL, $urandom_range(0, 20),
                         0, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 63));
            else if (r < 70)
                add_word(OP_TRIGGER, 0,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 20),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 11));
            else
                add_word(OP_TICK, $urandom_range(0, 63), $urandom_range(0, 127),
                         $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        operation = '0;
        position = '0;
        key = '0;
        value = '0;
        mismatches = 0;
        cycles = 0;
        hold_long = 1'b0;
        hold_cycles = 0;
        gap_enable = 1'b0;
        grid_rows = 1;
        grid_cols = 1;
        for (int i = 0; i < 64; i++)
        begin
            codes[i] = RC_NONE;
            cell_keys[i] = -7'sd1;
            key_pixels[i] = -7'sd1;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 1x1 grid tick, then a full 8x8 grid
        add_word(OP_TICK, 0, 0, 0);
        drain_all();
        write_reg(REG_ROWS, 32'd8);
        write_reg(REG_COLS, 32'd8);
        for (int i = 0; i < 8; i++)
            add_word(OP_SET_KEY, i * 9, 0, i);
        add_word(OP_SET_KEY, 63, 0, 127);   // wraps to key -1
        add_word(OP_SET_KEY, 62, 0, -128);  // stored as zero
        for (int i = 0; i < 8; i++)
            add_word(OP_SET_PIXEL, i, 0, i * 9);
        add_word(OP_SET_PIXEL, 63, 0, -1);
        add_word(OP_TRIGGER, 0, 3, 1);      // ripple in all directions
        add_word(OP_TRIGGER, 0, -1, 127);   // key -1 matches an unmapped cell
        add_word(OP_TRIGGER, 0, 63, -128);  // nothing holds it
        add_word(OP_TICK, 63, 63, 127);
        add_word(OP_TICK, 0, -64, -128);
        add_word(OP_TRIGGER, 0, 7, 9);
        add_word(OP_TICK, 0, 0, 0);
        drain_all();

        // random phases over several grid shapes, extremes and out of range
        gap_enable = 1'b1;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_ROWS, 32'd0); write_reg(REG_COLS, 32'd15); end
                1: begin write_reg(REG_ROWS, 32'd3); write_reg(REG_COLS, 32'd4); end
                2: begin write_reg(REG_ROWS, 32'd8); write_reg(REG_COLS, 32'd1); end
                3: begin write_reg(REG_ROWS, 32'd9); write_reg(REG_COLS, 32'd8); end
                default: begin write_reg(REG_ROWS, $urandom); write_reg(REG_COLS, $urandom); end
            endcase
            random_burst(45);
            if (ph == 2)
            begin
                // hold the receiver off while words keep coming
                hold_long = 1'b1;
                while (hold_cycles < 1500) @(posedge clk);
                hold_long = 1'b0;
            end
            drain_all();
        end

        if (mismatches == 0)
            $display("key_grid_ripple_led_effect regression: pass");
        else
            $display("key_grid_ripple_led_effect regression: fail");
        $finish;
    end

endmodule
